// ===== rtl/word_frame_bit_packer_macros.svh =====
// Assertion macros shared by the packer RTL.
`ifndef WORD_FRAME_BIT_PACKER_MACROS_SVH
`define WORD_FRAME_BIT_PACKER_MACROS_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define WFBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wfbp assertion failed");
// Check that cons holds in the cycle after ante.
`define WFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wfbp assertion failed");
`else
`define WFBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define WFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wfbp_pkg.sv =====
package wfbp_pkg;

	localparam int unsigned WORD_W     = 16;
	localparam int unsigned STOP_W     = 6;
	localparam int unsigned CNT_W      = 3;
	localparam int unsigned PEND_W     = 7;
	localparam int unsigned VEC_W      = 24;
	localparam int unsigned NBYTES_W   = 3;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [STOP_W-1:0] STOP_MIN   = 6'd1;
	localparam logic [STOP_W-1:0] STOP_MAX   = 6'd32;
	localparam logic [STOP_W-1:0] STOP_RESET = 6'd18;
	localparam logic [7:0]        BYTE_ONES  = 8'hFF;

	// One queued word: its bits left aligned (unused low bits are ones),
	// how many bytes it yields and whether it closes the frame.
	typedef struct packed {
		logic [VEC_W-1:0]    bits;
		logic [NBYTES_W-1:0] nbytes;
		logic                frame_end;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== rtl/wfbp_ifs.sv =====
interface wfbp_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;
	logic        frame_end;
	modport source(output valid, data_word, frame_end, input ready);
	modport sink(input valid, data_word, frame_end, output ready);
endinterface

interface wfbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       frame_done;
	modport source(output valid, out_byte, last_byte, frame_done, input ready);
	modport sink(input valid, out_byte, last_byte, frame_done, output ready);
endinterface

interface wfbp_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] stop_bits;
	modport source(output valid, stop_bits, input ready);
	modport sink(input valid, stop_bits, output ready);
endinterface

// ===== rtl/wfbp_front.sv =====
`include "word_frame_bit_packer_macros.svh"

module wfbp_front (
	input  logic                clk,
	input  logic                arst_n,
	wfbp_word_if.sink           words,
	wfbp_cfg_if.sink            cfg,
	input  wfbp_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output wfbp_pkg::cmd_t      push_cmd
);

	logic [wfbp_pkg::STOP_W-1:0] stop_bits_q;
	logic [wfbp_pkg::PEND_W-1:0] pend_bits_q;
	logic [wfbp_pkg::CNT_W-1:0]  pend_cnt_q;

	logic [wfbp_pkg::VEC_W-1:0]  raw;
	logic [wfbp_pkg::CNT_W-1:0]  gap;
	logic [wfbp_pkg::STOP_W-1:0] stop_eff;
	logic [wfbp_pkg::STOP_W-1:0] sum_plain;
	logic [wfbp_pkg::STOP_W-1:0] sum_last;

	assign cfg.ready   = 1'b1;
	assign words.ready = !fifo_stat.full;
	assign push        = words.valid && words.ready;

	always_comb begin
		// clamp stop length into 1..32
		if (stop_bits_q < wfbp_pkg::STOP_MIN) begin
			stop_eff = wfbp_pkg::STOP_MIN;
		end else if (stop_bits_q > wfbp_pkg::STOP_MAX) begin
			stop_eff = wfbp_pkg::STOP_MAX;
		end else begin
			stop_eff = stop_bits_q;
		end
		raw       = {pend_bits_q, words.data_word, 1'b1};
		gap       = 3'd7 - pend_cnt_q;
		// stale bits above the held count shift out the top
		push_cmd.bits = (raw << gap) | ~({wfbp_pkg::VEC_W{1'b1}} << gap);
		sum_plain = 6'(pend_cnt_q) + 6'd17;
		sum_last  = 6'(pend_cnt_q) + 6'd24 + stop_eff;
		push_cmd.nbytes    = words.frame_end ? sum_last[5:3] : sum_plain[5:3];
		push_cmd.frame_end = words.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_bits_q <= wfbp_pkg::STOP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			stop_bits_q <= cfg.stop_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (push) begin
			pend_bits_q <= raw[wfbp_pkg::PEND_W-1:0];
			pend_cnt_q  <= words.frame_end ? 3'd0 : sum_plain[2:0];
		end
	end

	`WFBP_ASSERT_NEXT(a_frame_flushes, clk, arst_n, push && words.frame_end, pend_cnt_q == 3'd0)

endmodule

// ===== rtl/wfbp_fifo.sv =====
`include "word_frame_bit_packer_macros.svh"

module wfbp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wfbp_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output wfbp_pkg::cmd_t       head,
	output wfbp_pkg::fifo_stat_t stat
);

	wfbp_pkg::cmd_t               mem_q [wfbp_pkg::FIFO_DEPTH];
	logic [wfbp_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [wfbp_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [wfbp_pkg::FIFO_CW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == wfbp_pkg::FIFO_CW'(wfbp_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`WFBP_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !stat.empty)
	`WFBP_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !stat.full)

endmodule

// ===== rtl/wfbp_back.sv =====
`include "word_frame_bit_packer_macros.svh"

module wfbp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	wfbp_byte_if.source          bytes,
	input  wfbp_pkg::cmd_t       head,
	input  wfbp_pkg::fifo_stat_t fifo_stat,
	output logic                 pop
);

	logic [wfbp_pkg::NBYTES_W-1:0] idx_q;
	logic                          valid_q;
	logic [7:0]                    byte_q;
	logic                          last_q;
	logic                          done_q;

	logic       load;
	logic       is_last;
	logic [7:0] byte_sel;

	assign load    = !valid_q || bytes.ready;
	assign is_last = (idx_q == head.nbytes - 1'b1);
	assign pop     = load && !fifo_stat.empty && is_last;

	always_comb begin
		unique case (idx_q)
			3'd0:    byte_sel = head.bits[23:16];
			3'd1:    byte_sel = head.bits[15:8];
			3'd2:    byte_sel = head.bits[7:0];
			default: byte_sel = wfbp_pkg::BYTE_ONES;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !fifo_stat.empty;
			if (!fifo_stat.empty) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !fifo_stat.empty) begin
			byte_q <= byte_sel;
			last_q <= is_last;
			done_q <= is_last && head.frame_end;
		end
	end

	assign bytes.valid      = valid_q;
	assign bytes.out_byte   = byte_q;
	assign bytes.last_byte  = last_q;
	assign bytes.frame_done = done_q;

	`WFBP_ASSERT_NOW(a_idx_in_word, clk, arst_n, !fifo_stat.empty, idx_q < head.nbytes)

endmodule

// ===== rtl/word_frame_bit_packer.sv =====
// Channel   Role    Payload
// words     sink    data_word[15:0], frame_end
// bytes     source  out_byte[7:0], last_byte, frame_done
// cfg       sink    stop_bits[5:0] (always ready)
//
// Each word becomes 2 or 3 bytes, a frame end up to 7; the byte output
// register issues one byte per cycle whenever bytes is ready to take it.
// The front takes one word per cycle while the 4-entry command queue has room.
// arst_n clears held bits, queue and output valid; stop_bits returns to 18.
// A stall on bytes only fills the queue; words stalls once it is full.
module word_frame_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	wfbp_word_if.sink   words,
	wfbp_byte_if.source bytes,
	wfbp_cfg_if.sink    cfg
);

	// front -> queue
	logic                 push;
	wfbp_pkg::cmd_t       push_cmd;
	// queue -> back
	wfbp_pkg::cmd_t       head;
	wfbp_pkg::fifo_stat_t fifo_stat;
	logic                 pop;

	// Front: hold the partial byte between words, align each word behind it
	// and work out how many whole bytes it (plus stop run and pad) yields.
	wfbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.cfg       (cfg),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Queue: decouple word intake from byte drain.
	wfbp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (fifo_stat)
	);

	// Back: step through the head command one byte per cycle unless bytes
	// stalls; bytes past the aligned word are all ones (stop run and pad),
	// drop the head on its last byte.
	wfbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop)
	);

endmodule

// ===== verif/tb_word_frame_bit_packer.sv =====
module tb_word_frame_bit_packer;
	timeunit 1ns;
	timeprecision 1ps;

	// Slowest run: about 500 words, each up to 7 bytes, each byte waiting out
	// the longest ready stall, plus the longest idle gap per word. This limit
	// leaves plenty of margin for it.
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASE_WORDS = 60;
	localparam int unsigned DRAIN_WAIT  = 24;
	localparam int unsigned BITS_PER_WORD = wfbp_pkg::WORD_W + 1;

	// One byte as it should appear on the byte channel.
	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       done;
	} byte_exp_t;

	// Directed row: a word, its frame flag and, when n_typed is nonzero, the
	// bytes it must yield (first byte in the top eight bits).
	typedef struct {
		logic [wfbp_pkg::WORD_W-1:0] word;
		logic                        fe;
		int                          n_typed;
		logic [55:0]                 typed;
	} dir_row_t;

	logic clk;
	logic arst_n;

	wfbp_word_if words_if();
	wfbp_byte_if bytes_if();
	wfbp_cfg_if  cfg_if();

	word_frame_bit_packer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words_if),
		.bytes  (bytes_if),
		.cfg    (cfg_if)
	);

	// Predictor state: held bits, their count and the stop run setting.
	logic [wfbp_pkg::PEND_W-1:0] held_bits;
	logic [wfbp_pkg::CNT_W-1:0]  held_cnt;
	logic [wfbp_pkg::STOP_W-1:0] stop_len;

	byte_exp_t   byte_q[$];
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit          idle_on;
	int unsigned ready_hold = 0;

	// Directed table. The first three rows follow reset (nothing held, stop
	// run 18), so their bytes can be written down directly. The rest walk the
	// held count through all eight values and close a frame with seven held.
	dir_row_t dir_rows [20] = '{
		'{16'hFFFF, 1'b1, 5, 56'hFFFF_FFFF_FF00_00},  // all ones, frame end
		'{16'h0000, 1'b0, 2, 56'h0000_0000_0000_00},  // zeros, one separator held
		'{16'h0000, 1'b1, 5, 56'h8000_7FFF_FF00_00},  // held separator leads
		'{16'h8000, 1'b0, 0, 56'h0},
		'{16'h0001, 1'b0, 0, 56'h0},
		'{16'hAAAA, 1'b0, 0, 56'h0},
		'{16'h5555, 1'b0, 0, 56'h0},
		'{16'hFFFF, 1'b0, 0, 56'h0},
		'{16'h0000, 1'b0, 0, 56'h0},
		'{16'h1234, 1'b0, 0, 56'h0},
		'{16'hFEDC, 1'b0, 0, 56'h0},
		'{16'h7FFF, 1'b0, 0, 56'h0},
		'{16'hFFFE, 1'b0, 0, 56'h0},
		'{16'h0F0F, 1'b0, 0, 56'h0},
		'{16'hF0F0, 1'b0, 0, 56'h0},
		'{16'h00FF, 1'b0, 0, 56'h0},
		'{16'hFF00, 1'b0, 0, 56'h0},
		'{16'hC3A5, 1'b0, 0, 56'h0},
		'{16'h7FFF, 1'b1, 0, 56'h0},  // frame end with seven bits held
		'{16'h8001, 1'b1, 0, 56'h0}   // single-word frame
	};

	// Stop run per random phase: low clamp, minimum, maximum, high clamp,
	// a length that needs no pad after one word, one above the maximum.
	logic [wfbp_pkg::STOP_W-1:0] phase_stop [8] =
		'{6'd0, 6'd1, 6'd32, 6'd63, 6'd7, 6'd33, 6'd15, 6'd0};

	always #4 clk = ~clk;

	// Pack one word into bytes and advance the held state.
	function automatic void pack_word(input logic [wfbp_pkg::WORD_W-1:0] w, input logic fe,
			output byte_exp_t res [7], output int nres);
		logic [63:0] acc;
		int unsigned nbits;
		int unsigned run;
		int unsigned pad;
		acc   = 64'(held_bits) & ((64'd1 << held_cnt) - 64'd1);
		nbits = held_cnt;
		acc   = (acc << BITS_PER_WORD) | (64'(w) << 1) | 64'd1;
		nbits += BITS_PER_WORD;
		if (fe) begin
			run = stop_len;
			if (run < wfbp_pkg::STOP_MIN) run = wfbp_pkg::STOP_MIN;
			if (run > wfbp_pkg::STOP_MAX) run = wfbp_pkg::STOP_MAX;
			acc = (acc << run) | ((64'd1 << run) - 64'd1);
			nbits += run;
			pad = (8 - (nbits % 8)) % 8;
			acc = (acc << pad) | ((64'd1 << pad) - 64'd1);
			nbits += pad;
		end
		nres = 0;
		while (nbits >= 8) begin
			nbits -= 8;
			res[nres].data = acc[nbits +: 8];
			res[nres].last = 1'b0;
			res[nres].done = 1'b0;
			nres++;
		end
		res[nres-1].last = 1'b1;
		res[nres-1].done = fe;
		held_cnt  = wfbp_pkg::CNT_W'(nbits);
		held_bits = wfbp_pkg::PEND_W'(acc & ((64'd1 << nbits) - 64'd1));
	endfunction

	// Offer one word, hold it until taken, then queue its bytes.
	task automatic send_word(input logic [wfbp_pkg::WORD_W-1:0] w, input logic fe,
			input int n_typed, input logic [55:0] typed);
		byte_exp_t res [7];
		int nres;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			words_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		words_if.valid     <= 1'b1;
		words_if.data_word <= w;
		words_if.frame_end <= fe;
		@(posedge clk);
		while (!words_if.ready) @(posedge clk);
		pack_word(w, fe, res, nres);
		if (n_typed != 0) begin
			nres = n_typed;
			for (int i = 0; i < nres; i++) begin
				res[i].data = typed[55 - 8*i -: 8];
				res[i].last = (i == nres - 1);
				res[i].done = (i == nres - 1) && fe;
			end
		end
		for (int i = 0; i < nres; i++) byte_q.push_back(res[i]);
	endtask

	// Let all queued bytes drain, then let the block settle before going on.
	task automatic drain_bytes();
		while (byte_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write the stop run length; only called with the block idle.
	task automatic write_stop(input logic [wfbp_pkg::STOP_W-1:0] value);
		cfg_if.valid     <= 1'b1;
		cfg_if.stop_bits <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		stop_len = value;
	endtask

	// Random word content, with the field extremes mixed in.
	function automatic logic [wfbp_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h0001;
			default: return wfbp_pkg::WORD_W'($urandom);
		endcase
	endfunction

	// Byte sink: drop ready for random bursts while idling is on.
	always @(posedge clk) begin
		if (!arst_n) begin
			bytes_if.ready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			if (ready_hold == 1) bytes_if.ready <= 1'b1;
			ready_hold <= ready_hold - 1;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			bytes_if.ready <= 1'b0;
			ready_hold <= $urandom_range(1, 18);
		end
	end

	// Compare every byte taken against the oldest expectation.
	always @(posedge clk) begin
		byte_exp_t want;
		if (arst_n && bytes_if.valid && bytes_if.ready) begin
			if (byte_q.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %02h last %b done %b",
					$time, bytes_if.out_byte, bytes_if.last_byte, bytes_if.frame_done);
				err_cnt++;
			end else begin
				want = byte_q.pop_front();
				if (bytes_if.out_byte !== want.data || bytes_if.last_byte !== want.last ||
						bytes_if.frame_done !== want.done) begin
					$display("%0t: byte mismatch: expected %02h last %b done %b, %s",
						$time, want.data, want.last, want.done, "actual");
					$display("%0t:   actual %02h last %b done %b",
						$time, bytes_if.out_byte, bytes_if.last_byte, bytes_if.frame_done);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned left;
		int unsigned flen;
		logic fe;
		clk        = 1'b0;
		idle_on    = 1'b1;
		held_bits  = '0;
		held_cnt   = '0;
		stop_len   = wfbp_pkg::STOP_RESET;
		arst_n             <= 1'b0;
		words_if.valid     <= 1'b0;
		words_if.data_word <= '0;
		words_if.frame_end <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.stop_bits   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the reset stop length.
		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].fe, dir_rows[i].n_typed, dir_rows[i].typed);

		// Random phases: frames of random length, one stop setting each. Every
		// other phase runs without idling; the last one never idles.
		foreach (phase_stop[p]) begin
			words_if.valid <= 1'b0;
			drain_bytes();
			idle_on = (p % 2 == 0) && (p != 7);
			if (p == 6) write_stop(wfbp_pkg::STOP_W'($urandom_range(0, 63)));
			else write_stop(phase_stop[p]);
			left = PHASE_WORDS;
			while (left != 0) begin
				flen = $urandom_range(1, 12);
				if (flen > left) flen = left;
				for (int k = 0; k < flen; k++) begin
					fe = (k == flen - 1);
					send_word(pick_word(), fe, 0, 56'h0);
				end
				left -= flen;
			end
		end

		words_if.valid <= 1'b0;
		drain_bytes();
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
